>>> sv/qihp_pkg.sv
// Shared types and constants for the QUIC invariant header parser.
package qihp_pkg;

    // Default ceiling on a connection id length
    localparam int MAX_ID_LEN_DEF = 20;

    // Reset value of the short-header id length register
    localparam logic [4:0] LOCAL_LEN_RESET = 5'd8;

    // Result queue depth; one input byte can push two results
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Saturation point of the header byte count
    localparam logic [5:0] HDR_LEN_MAX = 6'd63;

    // Number of version bytes in a long header
    localparam int VERSION_BYTES = 4;

    // Header form bit of the first byte
    localparam int FORM_BIT = 7;

    // Parse phases
    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_VERSION = 3'd1,
        PH_DLEN    = 3'd2,
        PH_DBYTES  = 3'd3,
        PH_SLEN    = 3'd4,
        PH_SBYTES  = 3'd5,
        PH_SHORT   = 3'd6,
        PH_SKIP    = 3'd7
    } phase_t;

    // Record kinds
    localparam logic [1:0] KIND_VERSION = 2'd0;
    localparam logic [1:0] KIND_DEST    = 2'd1;
    localparam logic [1:0] KIND_SOURCE  = 2'd2;
    localparam logic [1:0] KIND_SUMMARY = 2'd3;

    // Summary status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_TRUNCATED = 2'd1;
    localparam logic [1:0] STAT_TOO_LONG  = 2'd2;

    // One result word
    typedef struct packed {
        logic [1:0]  record_kind;
        logic [31:0] field_value;
        logic [4:0]  id_byte_index;
        logic [1:0]  parse_status;
        logic [5:0]  header_length;
        logic        is_long_header;
        logic [7:0]  first_header_byte;
        logic [4:0]  dest_id_length;
        logic [4:0]  source_id_length;
        logic        run_end;
    } result_t;

endpackage

>>> sv/qihp_fifo.sv
// Small result queue that takes up to two words per cycle and gives one.
module qihp_fifo
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [1:0]                          push_n,
    input  qihp_pkg::result_t                   wdata0,
    input  qihp_pkg::result_t                   wdata1,
    input  logic                                pop,
    output qihp_pkg::result_t                   head,
    output logic [qihp_pkg::FIFO_CNT_W-1:0]     count
);

    qihp_pkg::result_t                      mem [qihp_pkg::FIFO_DEPTH];
    logic [qihp_pkg::FIFO_PTR_W-1:0]        wptr_reg;
    logic [qihp_pkg::FIFO_PTR_W-1:0]        wptr_next;
    logic [qihp_pkg::FIFO_PTR_W-1:0]        wptr_plus1;
    logic [qihp_pkg::FIFO_PTR_W-1:0]        rptr_reg;
    logic [qihp_pkg::FIFO_PTR_W-1:0]        rptr_next;
    logic [qihp_pkg::FIFO_CNT_W-1:0]        count_reg;
    logic [qihp_pkg::FIFO_CNT_W-1:0]        count_next;

    // Advance pointers and occupancy
    always_comb
    begin
        wptr_plus1 = wptr_reg + qihp_pkg::FIFO_PTR_W'(1);
        wptr_next  = wptr_reg + qihp_pkg::FIFO_PTR_W'(push_n);
        rptr_next  = pop ? rptr_reg + qihp_pkg::FIFO_PTR_W'(1) : rptr_reg;
        count_next = count_reg + qihp_pkg::FIFO_CNT_W'(push_n)
                     - qihp_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Store pushed words
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem[wptr_reg] <= wdata0;
        end
        if (push_n == 2'd2)
        begin
            mem[wptr_plus1] <= wdata1;
        end
    end

    assign head  = mem[rptr_reg];
    assign count = count_reg;

    // Never overfill or pop an empty queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= qihp_pkg::FIFO_CNT_W'(qihp_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("pop from empty result queue");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n == 2'd0 && !pop) |=> $stable(count_reg))
        else $error("queue count moved without push or pop");

endmodule

>>> sv/quic_invariant_header_parser.sv
// Top level of the QUIC invariant header parser: byte parser and result queue.
// The parser takes one datagram byte per cycle and turns it into at most two
// result words (an id byte or version word, then possibly the header summary),
// which go into a four-word queue in the same cycle. in_stall rises only while
// the queue has fewer than two free words, so with a consumer that takes one
// word a cycle the block sustains one byte per cycle; a byte that yields both
// a record and a summary pushes two words. Results leave the queue in the
// order their bytes were accepted. The local id length register may be
// written only while no datagram is in progress.
module quic_invariant_header_parser
#(
    parameter int MAX_ID_LEN = qihp_pkg::MAX_ID_LEN_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    // byte input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        final_byte,
    // result output
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  record_kind,
    output logic [31:0] field_value,
    output logic [4:0]  id_byte_index,
    output logic [1:0]  parse_status,
    output logic [5:0]  header_length,
    output logic        is_long_header,
    output logic [7:0]  first_header_byte,
    output logic [4:0]  dest_id_length,
    output logic [4:0]  source_id_length,
    output logic        run_end
);

    localparam int LEN_W = (MAX_ID_LEN < 2) ? 1 : $clog2(MAX_ID_LEN + 1);
    localparam int CNT_W = (LEN_W < 3) ? 3 : LEN_W;

    logic [4:0]                         local_len_reg;
    qihp_pkg::phase_t                   phase_reg;
    qihp_pkg::phase_t                   phase_next;
    logic [CNT_W-1:0]                   cnt_reg;
    logic [CNT_W-1:0]                   cnt_next;
    logic [31:0]                        vers_reg;
    logic [31:0]                        vers_next;
    logic [5:0]                         cons_reg;
    logic [5:0]                         cons_next;
    logic [7:0]                         first_reg;
    logic [7:0]                         first_next;
    logic                               long_reg;
    logic                               long_next;
    logic [LEN_W-1:0]                   dlen_reg;
    logic [LEN_W-1:0]                   dlen_next;
    logic [LEN_W-1:0]                   slen_reg;
    logic [LEN_W-1:0]                   slen_next;

    logic                               accept;
    logic                               pop;
    logic [CNT_W:0]                     cnt_inc;
    logic                               byte_too_long;
    logic                               local_too_long;
    logic                               rec_valid;
    qihp_pkg::result_t                  rec;
    logic                               sum_valid;
    logic [1:0]                         sum_status;
    qihp_pkg::result_t                  sum;
    logic                               dest_done;
    logic [1:0]                         push_n;
    qihp_pkg::result_t                  wdata0;
    qihp_pkg::result_t                  wdata1;
    qihp_pkg::result_t                  head;
    logic [qihp_pkg::FIFO_CNT_W-1:0]    fifo_count;

    // Handshakes
    assign accept    = in_valid && !in_stall;
    assign pop       = out_valid && !out_stall;
    assign out_valid = (fifo_count != '0);
    assign in_stall  = (fifo_count > qihp_pkg::FIFO_CNT_W'(qihp_pkg::FIFO_DEPTH - 2));

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_len_reg <= qihp_pkg::LOCAL_LEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            local_len_reg <= cfg_wr_data;
        end
    end

    assign cnt_inc        = (CNT_W + 1)'(cnt_reg) + (CNT_W + 1)'(1);
    assign byte_too_long  = (9'(data_byte) > 9'(MAX_ID_LEN));
    assign local_too_long = (9'(local_len_reg) > 9'(MAX_ID_LEN));

    // Parse one byte: next state, id/version record and summary decision
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        vers_next  = vers_reg;
        cons_next  = (cons_reg < qihp_pkg::HDR_LEN_MAX) ? cons_reg + 6'd1 : cons_reg;
        first_next = first_reg;
        long_next  = long_reg;
        dlen_next  = dlen_reg;
        slen_next  = slen_reg;
        rec_valid  = 1'b0;
        rec        = '0;
        sum_valid  = 1'b0;
        sum_status = qihp_pkg::STAT_OK;

        unique case (phase_reg)
            qihp_pkg::PH_SKIP:
            begin
                cons_next = cons_reg;
                if (final_byte)
                begin
                    phase_next = qihp_pkg::PH_FIRST;
                end
            end
            qihp_pkg::PH_FIRST:
            begin
                cons_next  = 6'd1;
                first_next = data_byte;
                long_next  = data_byte[qihp_pkg::FORM_BIT];
                dlen_next  = '0;
                slen_next  = '0;
                cnt_next   = '0;
                vers_next  = '0;
                if (local_too_long)
                begin
                    sum_valid  = 1'b1;
                    sum_status = qihp_pkg::STAT_TOO_LONG;
                end
                else if (data_byte[qihp_pkg::FORM_BIT])
                begin
                    phase_next = qihp_pkg::PH_VERSION;
                end
                else
                begin
                    dlen_next = LEN_W'(local_len_reg);
                    if (local_len_reg == 5'd0)
                    begin
                        sum_valid = 1'b1;
                    end
                    else
                    begin
                        phase_next = qihp_pkg::PH_SHORT;
                    end
                end
            end
            qihp_pkg::PH_SHORT:
            begin
                rec_valid         = 1'b1;
                rec.record_kind   = qihp_pkg::KIND_DEST;
                rec.field_value   = 32'(data_byte);
                rec.id_byte_index = 5'(cnt_reg);
                cnt_next          = CNT_W'(cnt_inc);
                if (cnt_inc >= (CNT_W + 1)'(dlen_reg))
                begin
                    sum_valid = 1'b1;
                end
            end
            qihp_pkg::PH_VERSION:
            begin
                vers_next = {vers_reg[23:0], data_byte};
                cnt_next  = CNT_W'(cnt_inc);
                if (cnt_inc >= (CNT_W + 1)'(qihp_pkg::VERSION_BYTES))
                begin
                    rec_valid       = 1'b1;
                    rec.record_kind = qihp_pkg::KIND_VERSION;
                    rec.field_value = {vers_reg[23:0], data_byte};
                    cnt_next        = '0;
                    phase_next      = qihp_pkg::PH_DLEN;
                end
            end
            qihp_pkg::PH_DLEN:
            begin
                if (byte_too_long)
                begin
                    sum_valid  = 1'b1;
                    sum_status = qihp_pkg::STAT_TOO_LONG;
                end
                else
                begin
                    dlen_next  = LEN_W'(data_byte);
                    cnt_next   = '0;
                    phase_next = (data_byte == 8'd0) ? qihp_pkg::PH_SLEN
                                                     : qihp_pkg::PH_DBYTES;
                end
            end
            qihp_pkg::PH_DBYTES:
            begin
                rec_valid         = 1'b1;
                rec.record_kind   = qihp_pkg::KIND_DEST;
                rec.field_value   = 32'(data_byte);
                rec.id_byte_index = 5'(cnt_reg);
                cnt_next          = CNT_W'(cnt_inc);
                if (cnt_inc >= (CNT_W + 1)'(dlen_reg))
                begin
                    cnt_next   = '0;
                    phase_next = qihp_pkg::PH_SLEN;
                end
            end
            qihp_pkg::PH_SLEN:
            begin
                if (byte_too_long)
                begin
                    sum_valid  = 1'b1;
                    sum_status = qihp_pkg::STAT_TOO_LONG;
                end
                else
                begin
                    slen_next = LEN_W'(data_byte);
                    cnt_next  = '0;
                    if (data_byte == 8'd0)
                    begin
                        sum_valid = 1'b1;
                    end
                    else
                    begin
                        phase_next = qihp_pkg::PH_SBYTES;
                    end
                end
            end
            qihp_pkg::PH_SBYTES:
            begin
                rec_valid         = 1'b1;
                rec.record_kind   = qihp_pkg::KIND_SOURCE;
                rec.field_value   = 32'(data_byte);
                rec.id_byte_index = 5'(cnt_reg);
                cnt_next          = CNT_W'(cnt_inc);
                if (cnt_inc >= (CNT_W + 1)'(slen_reg))
                begin
                    sum_valid = 1'b1;
                end
            end
            default:
            begin
                phase_next = qihp_pkg::PH_FIRST;
            end
        endcase

        // A final byte that leaves the header open ends it as truncated
        if (phase_reg != qihp_pkg::PH_SKIP && !sum_valid && final_byte)
        begin
            sum_valid  = 1'b1;
            sum_status = qihp_pkg::STAT_TRUNCATED;
        end

        // The destination id counts as complete once parsing has moved past it
        dest_done = (sum_status == qihp_pkg::STAT_OK)
                    || (phase_next == qihp_pkg::PH_SLEN)
                    || (phase_next == qihp_pkg::PH_SBYTES);

        // Close the datagram or drop the rest of it
        if (sum_valid)
        begin
            phase_next = final_byte ? qihp_pkg::PH_FIRST : qihp_pkg::PH_SKIP;
        end
    end

    // Build the summary word from the updated header state
    always_comb
    begin
        sum                   = '0;
        sum.record_kind       = qihp_pkg::KIND_SUMMARY;
        sum.parse_status      = sum_status;
        sum.header_length     = cons_next;
        sum.is_long_header    = long_next;
        sum.first_header_byte = first_next;
        sum.dest_id_length    = dest_done ? 5'(dlen_next) : 5'd0;
        sum.source_id_length  = (sum_status == qihp_pkg::STAT_OK) ? 5'(slen_next) : 5'd0;
        sum.run_end           = 1'b1;
    end

    // Pack the words of this byte into the queue, last one flagged
    always_comb
    begin
        wdata0 = rec;
        wdata1 = sum;
        push_n = 2'd0;
        if (accept)
        begin
            if (rec_valid && sum_valid)
            begin
                push_n = 2'd2;
            end
            else if (rec_valid)
            begin
                push_n         = 2'd1;
                wdata0.run_end = 1'b1;
            end
            else if (sum_valid)
            begin
                push_n = 2'd1;
                wdata0 = sum;
            end
        end
    end

    // Header state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= qihp_pkg::PH_FIRST;
            cnt_reg   <= '0;
            vers_reg  <= '0;
            cons_reg  <= '0;
            first_reg <= '0;
            long_reg  <= 1'b0;
            dlen_reg  <= '0;
            slen_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            vers_reg  <= vers_next;
            cons_reg  <= cons_next;
            first_reg <= first_next;
            long_reg  <= long_next;
            dlen_reg  <= dlen_next;
            slen_reg  <= slen_next;
        end
    end

    qihp_fifo u_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push_n (push_n),
        .wdata0 (wdata0),
        .wdata1 (wdata1),
        .pop    (pop),
        .head   (head),
        .count  (fifo_count)
    );

    // Drive the output fields from the queue head
    assign record_kind       = head.record_kind;
    assign field_value       = head.field_value;
    assign id_byte_index     = head.id_byte_index;
    assign parse_status      = head.parse_status;
    assign header_length     = head.header_length;
    assign is_long_header    = head.is_long_header;
    assign first_header_byte = head.first_header_byte;
    assign dest_id_length    = head.dest_id_length;
    assign source_id_length  = head.source_id_length;
    assign run_end           = head.run_end;

    // Skipped bytes produce nothing
    a_skip_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == qihp_pkg::PH_SKIP) |-> (push_n == 2'd0))
        else $error("word pushed for a skipped byte");

    // A final byte inside a header always closes it with a summary
    a_final_summary: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && final_byte && phase_reg != qihp_pkg::PH_SKIP) |-> sum_valid)
        else $error("final byte without a summary");

    // After a summary the parser waits for a new datagram or skips
    a_after_summary: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && sum_valid)
        |=> (phase_reg == qihp_pkg::PH_FIRST || phase_reg == qihp_pkg::PH_SKIP))
        else $error("parser kept parsing after a summary");

    // The short id byte count stays below the latched length
    a_short_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == qihp_pkg::PH_SHORT) |-> ((CNT_W + 1)'(cnt_reg) < (CNT_W + 1)'(dlen_reg)))
        else $error("short id byte count out of range");

endmodule

>>> tb/quic_invariant_header_parser_tb.sv
// Self-checking testbench for the QUIC invariant header parser.
module quic_invariant_header_parser_tb;

    localparam int MAX_ID        = qihp_pkg::MAX_ID_LEN_DEF;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 200;
    localparam int CYCLE_LIMIT   = 500000;

    typedef logic [7:0] byte_q_t[$];

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [4:0]  cfg_wr_data = '0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte   = '0;
    logic        final_byte  = 1'b0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [1:0]  record_kind;
    logic [31:0] field_value;
    logic [4:0]  id_byte_index;
    logic [1:0]  parse_status;
    logic [5:0]  header_length;
    logic        is_long_header;
    logic [7:0]  first_header_byte;
    logic [4:0]  dest_id_length;
    logic [4:0]  source_id_length;
    logic        run_end;

    // Header parser state as the testbench tracks it
    qihp_pkg::phase_t hdr_phase   = qihp_pkg::PH_FIRST;
    logic [4:0]       id_count    = '0;
    logic [31:0]      version_acc = '0;
    logic [5:0]       consumed    = '0;
    logic [7:0]       first_byte  = '0;
    logic             long_form   = 1'b0;
    logic [4:0]       dest_len    = '0;
    logic [4:0]       src_len     = '0;
    logic [4:0]       local_len   = qihp_pkg::LOCAL_LEN_RESET;

    qihp_pkg::result_t pending_records[$];
    int          mismatch_count = 0;
    int          item_count     = 0;
    int          cycle_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    logic        hold_on        = 1'b0;
    event        stall_burst;

    quic_invariant_header_parser u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .data_byte         (data_byte),
        .final_byte        (final_byte),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .record_kind       (record_kind),
        .field_value       (field_value),
        .id_byte_index     (id_byte_index),
        .parse_status      (parse_status),
        .header_length     (header_length),
        .is_long_header    (is_long_header),
        .first_header_byte (first_header_byte),
        .dest_id_length    (dest_id_length),
        .source_id_length  (source_id_length),
        .run_end           (run_end)
    );

    // Clock: period 8
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("quic_invariant_header_parser test failed");
            $finish;
        end
    end

    // Hold the output stalled for a long stretch on request
    always
    begin
        @(stall_burst);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    // Stall the output side at random
    always @(posedge clk)
    begin
        out_stall <= hold_on || ($urandom_range(99) < recv_stall_pct);
    end

    function automatic string record_text(input qihp_pkg::result_t r);
        return $sformatf({"kind=%0d value=%h idx=%0d status=%0d len=%0d long=%b first=%h",
                          " dlen=%0d slen=%0d end=%b"},
                         r.record_kind, r.field_value, r.id_byte_index, r.parse_status,
                         r.header_length, r.is_long_header, r.first_header_byte,
                         r.dest_id_length, r.source_id_length, r.run_end);
    endfunction

    task automatic note_mismatch(input string what, input string want_txt, input string got_txt);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("MISMATCH %s: expected %s, actual %s", what, want_txt, got_txt);
    endtask

    // Compare each accepted output word with the oldest expected record
    always @(posedge clk)
    begin
        qihp_pkg::result_t seen;
        qihp_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            seen = {record_kind, field_value, id_byte_index, parse_status, header_length,
                    is_long_header, first_header_byte, dest_id_length, source_id_length,
                    run_end};
            if (pending_records.size() == 0)
                note_mismatch("unexpected word", "none", record_text(seen));
            else
            begin
                want = pending_records.pop_front();
                if (seen !== want)
                    note_mismatch("record", record_text(want), record_text(seen));
            end
        end
    end

    function automatic qihp_pkg::result_t id_record(input logic [1:0] kind,
                                                    input logic [31:0] value,
                                                    input logic [4:0] index);
        qihp_pkg::result_t r;
        r = '0;
        r.record_kind   = kind;
        r.field_value   = value;
        r.id_byte_index = index;
        return r;
    endfunction

    // Advance the header parse by one byte and queue the records it yields
    function automatic void parse_byte(input logic [7:0] b, input logic fin);
        qihp_pkg::result_t recs[$];
        qihp_pkg::result_t summary;
        bit                done;
        bit                dest_done;
        logic [1:0]        status;
        done   = 1'b0;
        status = qihp_pkg::STAT_OK;
        if (hdr_phase == qihp_pkg::PH_SKIP)
        begin
            if (fin)
                hdr_phase = qihp_pkg::PH_FIRST;
            return;
        end
        if (consumed < qihp_pkg::HDR_LEN_MAX)
            consumed++;
        case (hdr_phase)
            qihp_pkg::PH_FIRST:
            begin
                consumed    = 6'd1;
                first_byte  = b;
                long_form   = b[qihp_pkg::FORM_BIT];
                dest_len    = '0;
                src_len     = '0;
                id_count    = '0;
                version_acc = '0;
                if (local_len > MAX_ID)
                begin
                    done   = 1'b1;
                    status = qihp_pkg::STAT_TOO_LONG;
                end
                else if (long_form)
                    hdr_phase = qihp_pkg::PH_VERSION;
                else
                begin
                    dest_len = local_len;
                    if (local_len == 0)
                        done = 1'b1;
                    else
                        hdr_phase = qihp_pkg::PH_SHORT;
                end
            end
            qihp_pkg::PH_SHORT:
            begin
                recs.push_back(id_record(qihp_pkg::KIND_DEST, b, id_count));
                id_count++;
                if (id_count >= dest_len)
                    done = 1'b1;
            end
            qihp_pkg::PH_VERSION:
            begin
                version_acc = {version_acc[23:0], b};
                id_count++;
                if (id_count >= qihp_pkg::VERSION_BYTES)
                begin
                    recs.push_back(id_record(qihp_pkg::KIND_VERSION, version_acc, '0));
                    id_count  = '0;
                    hdr_phase = qihp_pkg::PH_DLEN;
                end
            end
            qihp_pkg::PH_DLEN:
            begin
                if (b > MAX_ID)
                begin
                    done   = 1'b1;
                    status = qihp_pkg::STAT_TOO_LONG;
                end
                else
                begin
                    dest_len  = b[4:0];
                    id_count  = '0;
                    hdr_phase = (b == 0) ? qihp_pkg::PH_SLEN : qihp_pkg::PH_DBYTES;
                end
            end
            qihp_pkg::PH_DBYTES:
            begin
                recs.push_back(id_record(qihp_pkg::KIND_DEST, b, id_count));
                id_count++;
                if (id_count >= dest_len)
                begin
                    id_count  = '0;
                    hdr_phase = qihp_pkg::PH_SLEN;
                end
            end
            qihp_pkg::PH_SLEN:
            begin
                if (b > MAX_ID)
                begin
                    done   = 1'b1;
                    status = qihp_pkg::STAT_TOO_LONG;
                end
                else
                begin
                    src_len  = b[4:0];
                    id_count = '0;
                    if (b == 0)
                        done = 1'b1;
                    else
                        hdr_phase = qihp_pkg::PH_SBYTES;
                end
            end
            default:
            begin
                recs.push_back(id_record(qihp_pkg::KIND_SOURCE, b, id_count));
                id_count++;
                if (id_count >= src_len)
                    done = 1'b1;
            end
        endcase

        // A final byte before the header is complete truncates it
        if (!done && fin)
        begin
            done   = 1'b1;
            status = qihp_pkg::STAT_TRUNCATED;
        end
        if (done)
        begin
            dest_done = (status == qihp_pkg::STAT_OK) || hdr_phase == qihp_pkg::PH_SLEN
                        || hdr_phase == qihp_pkg::PH_SBYTES;
            summary = '0;
            summary.record_kind       = qihp_pkg::KIND_SUMMARY;
            summary.parse_status      = status;
            summary.header_length     = consumed;
            summary.is_long_header    = long_form;
            summary.first_header_byte = first_byte;
            summary.dest_id_length    = dest_done ? dest_len : '0;
            summary.source_id_length  = (status == qihp_pkg::STAT_OK) ? src_len : '0;
            recs.push_back(summary);
            hdr_phase = fin ? qihp_pkg::PH_FIRST : qihp_pkg::PH_SKIP;
        end
        if (recs.size() > 0)
            recs[recs.size() - 1].run_end = 1'b1;
        foreach (recs[i])
            pending_records.push_back(recs[i]);
    endfunction

    // Offer one byte, idling first at random, and wait for it to be taken
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        final_byte <= fin;
        do
            @(posedge clk);
        while (in_stall);
        parse_byte(b, fin);
        item_count++;
    endtask

    // Send a whole datagram, flagging its last byte
    task automatic send_frame(input byte_q_t frame);
        foreach (frame[i])
            send_byte(frame[i], i == frame.size() - 1);
    endtask

    // Drop valid and wait until every expected word has come out or the drain limit runs out
    task automatic wait_idle();
        int waited;
        in_valid <= 1'b0;
        for (waited = 0; pending_records.size() != 0 && waited < DRAIN_LIMIT; waited++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_local_len(input logic [4:0] len);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        local_len = len;
    endtask

    function automatic int pick_id_len();
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: return $urandom_range(8);
            6, 7:             return $urandom_range(MAX_ID);
            8:                return MAX_ID;
            default:          return 0;
        endcase
    endfunction

    function automatic logic [4:0] pick_local_len();
        case ($urandom_range(7))
            0:       return 5'd0;
            1:       return 5'(MAX_ID);
            2:       return 5'($urandom_range(31, MAX_ID + 1));
            default: return 5'($urandom_range(MAX_ID, 1));
        endcase
    endfunction

    // Build one datagram: mostly well-formed headers, some truncated,
    // some with an oversized id length, some plain noise
    function automatic byte_q_t random_frame();
        byte_q_t f;
        int      shape;
        int      dl;
        int      sl;
        int      cut;
        shape = $urandom_range(9);
        if (shape == 9)
        begin
            repeat ($urandom_range(8, 1)) f.push_back(8'($urandom));
            return f;
        end
        if (shape < 3)
        begin
            f.push_back({1'b0, 7'($urandom)});
            repeat (local_len) f.push_back(8'($urandom));
        end
        else
        begin
            dl = pick_id_len();
            sl = pick_id_len();
            if (shape == 8)
            begin
                if ($urandom_range(1))
                    dl = $urandom_range(255, MAX_ID + 1);
                else
                    sl = $urandom_range(255, MAX_ID + 1);
            end
            f.push_back({1'b1, 7'($urandom)});
            repeat (qihp_pkg::VERSION_BYTES) f.push_back(8'($urandom));
            f.push_back(8'(dl));
            repeat (dl > MAX_ID ? 0 : dl) f.push_back(8'($urandom));
            f.push_back(8'(sl));
            repeat (sl > MAX_ID ? 0 : sl) f.push_back(8'($urandom));
        end
        if (shape == 7 && f.size() > 1)
        begin
            cut = $urandom_range(f.size() - 1, 1);
            f = f[0:cut - 1];
        end
        else
            repeat ($urandom_range(3)) f.push_back(8'($urandom));
        return f;
    endfunction

    // Extremes and special cases, one datagram each
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // empty short id completes on the first byte; trailing byte ignored
        write_local_len(5'd0);
        send_frame('{8'h00, 8'hFF});
        // local length above the id limit fails at once
        write_local_len(5'(MAX_ID + 1));
        send_frame('{8'hC3});
        write_local_len(5'd31);
        send_frame('{8'h12});
        // one-byte short id
        write_local_len(5'd1);
        send_frame('{8'h7F, 8'hAB});
        // long header, all-ones version, both ids empty
        send_frame('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00});
        // oversized destination length, rest of the datagram ignored
        send_frame('{8'h80, 8'h00, 8'h00, 8'h00, 8'h01, 8'h15, 8'h5A});
        // datagram ends inside the destination id
        send_frame('{8'hC0, 8'h12, 8'h34, 8'h56, 8'h78, 8'h02, 8'h11});
    endtask

    // Random datagrams, changing the local length at the next datagram once 40 more bytes have been sent
    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int quota);
        int start;
        int next_cfg;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        start    = item_count;
        next_cfg = item_count;
        while (item_count - start < quota)
        begin
            if (item_count >= next_cfg)
            begin
                write_local_len(pick_local_len());
                next_cfg = item_count + 40;
            end
            send_frame(random_frame());
        end
    endtask

    // Hold the output off while full-length short headers keep coming
    task automatic test_backpressure();
        byte_q_t f;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_local_len(5'(MAX_ID));
        -> stall_burst;
        repeat (3)
        begin
            f = {};
            f.push_back({1'b0, 7'($urandom)});
            repeat (MAX_ID) f.push_back(8'($urandom));
            send_frame(f);
        end
        wait_idle();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic(17, 81, 200);
        test_random_traffic(81, 17, 200);
        test_random_traffic(0, 0, 200);
        test_backpressure();

        wait_idle();
        if (pending_records.size() != 0)
            note_mismatch("missing words", $sformatf("%0d more", pending_records.size()),
                          "none");
        if (mismatch_count == 0)
            $display("quic_invariant_header_parser test passed");
        else
            $display("quic_invariant_header_parser test failed");
        $finish;
    end

endmodule
